[design/dtrt_pkg.sv]
// Package for the delayed trade return tracker.
// Shared types, widths, constants and helpers. No dependencies.
package dtrt_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int MAX_POPS    = 64;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int POP_W       = $clog2(MAX_POPS + 1);

    localparam int PRICE_W = 32;
    localparam int TAG_W   = 32;
    localparam int SIDE_W  = 2;
    localparam int BAR_W   = 16;
    localparam int HOR_W   = 12;
    localparam int FEE_W   = 25;
    localparam int RET_W   = 32;
    localparam int FRAC_W  = 24;
    localparam int DVD_W   = PRICE_W + FRAC_W;   // dividend and quotient width
    localparam int EXT_W   = DVD_W + 3;          // exact return width, signed

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = FEE_W;

    localparam logic [CFG_IDX_W-1:0] CFG_HORIZON = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLIP    = 2'd2;

    localparam logic       OP_DECISION = 1'b0;
    localparam logic       OP_BAR      = 1'b1;

    localparam logic [SIDE_W-1:0] SIDE_NONE  = 2'b00;
    localparam logic [SIDE_W-1:0] SIDE_LONG  = 2'b01;
    localparam logic [SIDE_W-1:0] SIDE_SHORT = 2'b11;

    localparam logic [HOR_W-1:0] HORIZON_RESET = 12'd4;

    localparam logic signed [EXT_W-1:0] ONE_Q = EXT_W'(1) <<< FRAC_W;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [PRICE_W-1:0] price;
        logic [SIDE_W-1:0]  side;
        logic [BAR_W-1:0]   open_bar;
        logic [HOR_W-1:0]   horizon;
    } t_slot;

    typedef struct packed {
        logic busy;
        logic valid;
    } t_div_stat;

    function automatic logic [RET_W-1:0] sat_ret(input logic signed [EXT_W-1:0] v);
        logic signed [EXT_W-1:0] hi;
        logic signed [EXT_W-1:0] lo;
        hi = (EXT_W'(1) <<< (RET_W - 1)) - EXT_W'(1);
        lo = -(EXT_W'(1) <<< (RET_W - 1));
        if (v > hi) begin
            return {1'b0, {(RET_W-1){1'b1}}};
        end else if (v < lo) begin
            return {1'b1, {(RET_W-1){1'b0}}};
        end else begin
            return v[RET_W-1:0];
        end
    endfunction

endpackage

[design/dtrt_ifs.sv]
// Channel interfaces of the tracker: input items, results, configuration.
// Depends on dtrt_pkg.
interface dtrt_in_if;
    logic                           valid;
    logic                           ready;
    logic                           op;
    logic signed [dtrt_pkg::SIDE_W-1:0] side;
    logic [dtrt_pkg::PRICE_W-1:0]   price;
    logic [dtrt_pkg::TAG_W-1:0]     row_tag;
    modport source (output valid, op, side, price, row_tag, input ready);
    modport sink   (input valid, op, side, price, row_tag, output ready);
endinterface

interface dtrt_out_if;
    logic                               valid;
    logic                               ready;
    logic [dtrt_pkg::TAG_W-1:0]         out_tag;
    logic signed [dtrt_pkg::SIDE_W-1:0] out_side;
    logic signed [dtrt_pkg::RET_W-1:0]  raw_return;
    logic signed [dtrt_pkg::RET_W-1:0]  net_return;
    logic                               last;
    modport source (output valid, out_tag, out_side, raw_return, net_return, last,
                    input ready);
    modport sink   (input valid, out_tag, out_side, raw_return, net_return, last,
                    output ready);
endinterface

interface dtrt_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [dtrt_pkg::CFG_IDX_W-1:0]    index;
    logic [dtrt_pkg::CFG_DATA_W-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[design/dtrt_slot_mem.sv]
// Slot memory of the trade queue: one write port, one registered read port.
// Depends on dtrt_pkg.
module dtrt_slot_mem (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [dtrt_pkg::PTR_W-1:0]    i_waddr,
    input  dtrt_pkg::t_slot               i_wdata,
    input  logic [dtrt_pkg::PTR_W-1:0]    i_raddr,
    output dtrt_pkg::t_slot               o_rdata
);
    dtrt_pkg::t_slot r_mem [dtrt_pkg::QUEUE_DEPTH];
    dtrt_pkg::t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[design/dtrt_divider.sv]
// Restoring divider, one quotient bit per cycle: (dividend / divisor).
// Depends on dtrt_pkg. Result holds until the next start.
module dtrt_divider (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [dtrt_pkg::DVD_W-1:0]     i_dividend,
    input  logic [dtrt_pkg::PRICE_W-1:0]   i_divisor,
    output dtrt_pkg::t_div_stat            o_stat,
    output logic [dtrt_pkg::DVD_W-1:0]     o_quot
);
    localparam int BIT_W = $clog2(dtrt_pkg::DVD_W + 1);

    logic                            r_busy, r_valid;
    logic [BIT_W-1:0]                r_bits;
    logic [dtrt_pkg::DVD_W-1:0]      r_quot;
    logic [dtrt_pkg::PRICE_W:0]      r_rem;
    logic [dtrt_pkg::PRICE_W-1:0]    r_div;
    logic [dtrt_pkg::PRICE_W:0]      n_shift;
    logic [dtrt_pkg::PRICE_W+1:0]    n_diff;

    always_comb begin
        n_shift = {r_rem[dtrt_pkg::PRICE_W-1:0], r_quot[dtrt_pkg::DVD_W-1]};
        n_diff  = {1'b0, n_shift} - {2'b00, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_bits  <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_valid <= 1'b0;
            r_bits  <= BIT_W'(dtrt_pkg::DVD_W);
            r_quot  <= i_dividend;
            r_rem   <= '0;
            r_div   <= i_divisor;
        end else if (r_busy) begin
            if (!n_diff[dtrt_pkg::PRICE_W+1]) begin
                r_rem <= n_diff[dtrt_pkg::PRICE_W:0];
            end else begin
                r_rem <= n_shift;
            end
            r_quot <= {r_quot[dtrt_pkg::DVD_W-2:0], ~n_diff[dtrt_pkg::PRICE_W+1]};
            r_bits <= r_bits - BIT_W'(1);
            if (r_bits == BIT_W'(1)) begin
                r_busy  <= 1'b0;
                r_valid <= 1'b1;
            end
        end
    end

    assign o_stat.busy  = r_busy;
    assign o_stat.valid = r_valid;
    assign o_quot       = r_quot;
endmodule

[design/delayed_trade_return_tracker_top.sv]
// Delayed trade return tracker, top level.
// Decisions transfer back to back while idle, one per cycle. A bar close holds ready low
// while the head slot is looked up and checked and, for each due entry popped, while its
// 56 quotient bits are divided at one a cycle and the result is captured, plus stalls.
// Synchronous active-low reset empties the queue, zeroes the bar count and
// loads horizon 4, fee 0, slip 0. Slot memory is not cleared.
module delayed_trade_return_tracker_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dtrt_in_if.sink       i_in,
    dtrt_out_if.source    o_out,
    dtrt_cfg_if.sink      i_cfg
);
    typedef enum logic [2:0] {S_IDLE, S_LOOK, S_CHK, S_DIV, S_FIN} t_state;

    t_state                             r_state;
    logic [dtrt_pkg::PTR_W-1:0]         r_head, r_tail;
    logic [dtrt_pkg::CNT_W-1:0]         r_fill;
    logic [dtrt_pkg::BAR_W-1:0]         r_bar;
    logic [dtrt_pkg::POP_W-1:0]         r_pops;
    logic [dtrt_pkg::PRICE_W-1:0]       r_close;
    logic [dtrt_pkg::HOR_W-1:0]         r_horizon;
    logic [dtrt_pkg::FEE_W-1:0]         r_fee, r_slip;

    // entry under division
    logic [dtrt_pkg::TAG_W-1:0]         r_e_tag;
    logic [dtrt_pkg::SIDE_W-1:0]        r_e_side;

    // finished result waiting for its last flag
    logic                               r_pend;
    logic [dtrt_pkg::TAG_W-1:0]         r_p_tag;
    logic [dtrt_pkg::SIDE_W-1:0]        r_p_side;
    logic [dtrt_pkg::RET_W-1:0]         r_p_raw, r_p_net;

    // output register
    logic                               r_oval;
    logic [dtrt_pkg::TAG_W-1:0]         r_o_tag;
    logic [dtrt_pkg::SIDE_W-1:0]        r_o_side;
    logic [dtrt_pkg::RET_W-1:0]         r_o_raw, r_o_net;
    logic                               r_o_last;

    logic                               in_xfer, out_free, div_start, mem_we, due;
    logic                               o_load;
    dtrt_pkg::t_slot                    wslot, rslot;
    dtrt_pkg::t_div_stat                div_stat;
    logic [dtrt_pkg::DVD_W-1:0]         quot;
    logic [dtrt_pkg::BAR_W-1:0]         age;
    logic signed [dtrt_pkg::EXT_W-1:0]  n_raw, n_net;

    function automatic logic [dtrt_pkg::PTR_W-1:0] nxt(input logic [dtrt_pkg::PTR_W-1:0] p);
        return (p == dtrt_pkg::PTR_W'(dtrt_pkg::QUEUE_DEPTH - 1)) ?
            '0 : p + dtrt_pkg::PTR_W'(1);
    endfunction

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_xfer     = i_in.valid && i_in.ready;
    assign out_free    = !r_oval || o_out.ready;
    // waiting result moves into the output register this cycle
    assign o_load      = r_pend && out_free && ((r_state == S_DIV) || (r_state == S_FIN));

    // decision enqueue
    assign mem_we = in_xfer && (i_in.op == dtrt_pkg::OP_DECISION) &&
                    (i_in.side != dtrt_pkg::SIDE_NONE) && (i_in.price != '0) &&
                    (r_fill < dtrt_pkg::CNT_W'(dtrt_pkg::QUEUE_DEPTH));
    always_comb begin
        wslot.tag      = i_in.row_tag;
        wslot.price    = i_in.price;
        wslot.side     = i_in.side;
        wslot.open_bar = r_bar;
        wslot.horizon  = r_horizon;
    end

    dtrt_slot_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_tail),
        .i_wdata (wslot),
        .i_raddr (r_head),
        .o_rdata (rslot)
    );

    // head entry is due once its age reaches its own stamped horizon
    assign age       = r_bar - rslot.open_bar;
    assign due       = ({{(dtrt_pkg::BAR_W-dtrt_pkg::HOR_W){1'b0}}, rslot.horizon} <= age);
    assign div_start = (r_state == S_CHK) && due;

    dtrt_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_close, {dtrt_pkg::FRAC_W{1'b0}}}),
        .i_divisor  (rslot.price),
        .o_stat     (div_stat),
        .o_quot     (quot)
    );

    // exact returns; a side other than long or short yields a zero raw return
    always_comb begin
        case (r_e_side)
            dtrt_pkg::SIDE_LONG:  n_raw = $signed({3'b000, quot}) - dtrt_pkg::ONE_Q;
            dtrt_pkg::SIDE_SHORT: n_raw = dtrt_pkg::ONE_Q - $signed({3'b000, quot});
            default:              n_raw = '0;
        endcase
        n_net = n_raw - $signed(dtrt_pkg::EXT_W'(r_fee)) - $signed(dtrt_pkg::EXT_W'(r_slip));
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_horizon <= dtrt_pkg::HORIZON_RESET;
            r_fee     <= '0;
            r_slip    <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                dtrt_pkg::CFG_HORIZON: r_horizon <= i_cfg.data[dtrt_pkg::HOR_W-1:0];
                dtrt_pkg::CFG_FEE:     r_fee     <= i_cfg.data;
                dtrt_pkg::CFG_SLIP:    r_slip    <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // control sequencer and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_fill  <= '0;
            r_bar   <= '0;
            r_pops  <= '0;
            r_pend  <= 1'b0;
            r_oval  <= 1'b0;
        end else begin
            if (o_load) begin
                r_oval <= 1'b1;
            end else if (r_oval && o_out.ready) begin
                r_oval <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (mem_we) begin
                        r_tail <= nxt(r_tail);
                        r_fill <= r_fill + dtrt_pkg::CNT_W'(1);
                    end
                    if (in_xfer && (i_in.op == dtrt_pkg::OP_BAR) && (i_in.price != '0)) begin
                        r_bar   <= r_bar + dtrt_pkg::BAR_W'(1);
                        r_close <= i_in.price;
                        r_pops  <= '0;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    // read of the head slot is under way
                    if ((r_fill != '0) && (r_pops < dtrt_pkg::POP_W'(dtrt_pkg::MAX_POPS))) begin
                        r_state <= S_CHK;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_CHK: begin
                    if (due) begin
                        r_e_tag  <= rslot.tag;
                        r_e_side <= rslot.side;
                        r_head   <= nxt(r_head);
                        r_fill   <= r_fill - dtrt_pkg::CNT_W'(1);
                        r_pops   <= r_pops + dtrt_pkg::POP_W'(1);
                        r_state  <= S_DIV;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_DIV: begin
                    // another entry follows, so the waiting result is not last
                    if (o_load) begin
                        r_o_tag  <= r_p_tag;
                        r_o_side <= r_p_side;
                        r_o_raw  <= r_p_raw;
                        r_o_net  <= r_p_net;
                        r_o_last <= 1'b0;
                        r_pend   <= 1'b0;
                    end
                    if (div_stat.valid && !r_pend) begin
                        r_pend   <= 1'b1;
                        r_p_tag  <= r_e_tag;
                        r_p_side <= r_e_side;
                        r_p_raw  <= dtrt_pkg::sat_ret(n_raw);
                        r_p_net  <= dtrt_pkg::sat_ret(n_net);
                        r_state  <= S_LOOK;
                    end
                end
                S_FIN: begin
                    if (!r_pend) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_o_tag  <= r_p_tag;
                        r_o_side <= r_p_side;
                        r_o_raw  <= r_p_raw;
                        r_o_net  <= r_p_net;
                        r_o_last <= 1'b1;
                        r_pend   <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid      = r_oval;
    assign o_out.out_tag    = r_o_tag;
    assign o_out.out_side   = r_o_side;
    assign o_out.raw_return = r_o_raw;
    assign o_out.net_return = r_o_net;
    assign o_out.last       = r_o_last;
endmodule

[design/dtrt_checker.sv]
// Port-level checks for the tracker, bound to the top level.
// Depends on dtrt_pkg and delayed_trade_return_tracker_top.
module dtrt_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_in_op,
    input logic [dtrt_pkg::PRICE_W-1:0]   i_in_price,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [dtrt_pkg::TAG_W-1:0]     i_out_tag,
    input logic [dtrt_pkg::SIDE_W-1:0]    i_out_side
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_tag) && $stable(i_out_side))
        else $error("stalled result changed");

    a_bar_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_op == dtrt_pkg::OP_BAR &&
        i_in_price != '0 |=> !i_in_ready)
        else $error("input ready during bar close processing");

    a_no_flat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_side != dtrt_pkg::SIDE_NONE)
        else $error("result with flat side");
endmodule

bind delayed_trade_return_tracker_top dtrt_checker u_dtrt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_op     (i_in.op),
    .i_in_price  (i_in.price),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_tag   (o_out.out_tag),
    .i_out_side  (o_out.out_side)
);
